// ===== src/d2q9_pkg.sv =====
// Shared constants of the D2Q9 collide block: lattice directions.
package d2q9_pkg;

   localparam int NDIR = 9;

   // Lattice velocity components, in population order sw, s, se, w, rest, e, nw, n, ne.
   localparam int DIR_EX [NDIR] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
   localparam int DIR_EY [NDIR] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};

endpackage

// ===== src/d2q9_mulq.sv =====
// Fixed-point multiply with floor shift and saturation to the value range.
module d2q9_mulq
   import d2q9_pkg::*;
#(
   parameter int AW = 24,
   parameter int BW = 24,
   parameter int V  = 24,
   parameter int F  = 20
) (
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [V-1:0]  y
);

   localparam int PW = AW + BW;
   localparam logic signed [PW-1:0] YMAX = PW'((longint'(1) << (V - 1)) - 1);
   localparam logic signed [PW-1:0] YMIN = ~YMAX;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] sh;

   assign prod = PW'(a) * PW'(b);
   assign sh   = prod >>> F;
   assign y    = (sh > YMAX) ? YMAX[V-1:0] : ((sh < YMIN) ? YMIN[V-1:0] : sh[V-1:0]);

endmodule

// ===== src/d2q9_div.sv =====
// Pipelined restoring divider: (num << F) / den, truncated toward zero, saturated.
module d2q9_div
   import d2q9_pkg::*;
#(
   parameter int V = 24,
   parameter int F = 20
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [V+2:0]   num,
   input  logic signed [V-1:0]   den,
   output logic signed [V-1:0]   quo
);

   localparam int JW = V + 3;
   localparam int NW = JW + F;
   localparam int RW = NW + V;

   logic [JW-1:0] un;
   logic [V-1:0]  ud;
   logic [RW-1:0] nq;

   logic [RW-1:0] rem_ff [V];
   logic [V-1:0]  dd_ff  [V];
   logic [V-1:0]  q_ff   [V+1];
   logic          neg_ff [V+1];
   logic          ovf_ff [V+1];
   logic          zero_ff[V+1];
   logic signed [V-1:0] quo_ff;

   logic [V-1:0] lim;
   logic [V-1:0] mag;

   assign un = num[JW-1] ? JW'(-num) : JW'(num);
   assign ud = den[V-1] ? V'(-den) : V'(den);
   assign nq = RW'({un, {F{1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= nq;
         dd_ff[0]   <= ud;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[JW-1] ^ den[V-1];
         ovf_ff[0]  <= nq >= (RW'(ud) << V);
         zero_ff[0] <= den == '0;
      end
   end

   for (genvar j = 1; j <= V; j++) begin : g_step
      logic [RW-1:0] sub_w;
      logic          ge_w;
      assign sub_w = RW'(dd_ff[j-1]) << (V - j);
      assign ge_w  = rem_ff[j-1] >= sub_w;
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]    <= q_ff[j-1] | (ge_w ? (V'(1) << (V - j)) : '0);
            neg_ff[j]  <= neg_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
         end
      end
      if (j < V) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge_w ? rem_ff[j-1] - sub_w : rem_ff[j-1];
               dd_ff[j]  <= dd_ff[j-1];
            end
         end
      end
   end

   assign lim = neg_ff[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
   assign mag = (ovf_ff[V] || q_ff[V] > lim) ? lim : q_ff[V];

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= zero_ff[V] ? '0 : (neg_ff[V] ? V'(-mag) : mag);
      end
   end

   assign quo = quo_ff;

endmodule

// ===== src/d2q9_lane.sv =====
// One direction lane: equilibrium and BGK relaxation of a single population.
module d2q9_lane
   import d2q9_pkg::*;
#(
   parameter int V  = 24,
   parameter int F  = 20,
   parameter int EX = 0,
   parameter int EY = 0
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [V-1:0] ux,
   input  logic signed [V-1:0] uy,
   input  logic signed [V-1:0] usq,
   input  logic signed [V-1:0] rho,
   input  logic signed [V-1:0] pop,
   input  logic                solid,
   input  logic [F+1:0]        omega,
   output logic signed [V-1:0] res
);

   localparam int SW   = ((V > F) ? V : F) + 4;
   localparam int CW   = F + 4;
   localparam int MANH = ((EX != 0) ? 1 : 0) + ((EY != 0) ? 1 : 0);
   localparam longint WL = (MANH == 0) ? (((longint'(4) << F) * 2 + 9) / 18) :
                           (MANH == 1) ? (((longint'(1) << F) * 2 + 9) / 18) :
                                         (((longint'(1) << F) * 2 + 36) / 72);
   localparam logic signed [CW-1:0] W_C   = CW'(WL);
   localparam logic signed [CW-1:0] C3_C  = CW'(longint'(3) << F);
   localparam logic signed [CW-1:0] C45_C = CW'((longint'(9) << F) / 2);
   localparam logic signed [CW-1:0] C15_C = CW'((longint'(3) << F) / 2);
   localparam logic signed [SW-1:0] ONE_S = SW'(longint'(1) << F);
   localparam logic signed [SW-1:0] SMAX  = SW'((longint'(1) << (V - 1)) - 1);
   localparam logic signed [SW-1:0] SMIN  = ~SMAX;

   function automatic logic signed [V-1:0] sat_v(input logic signed [SW-1:0] x);
      return (x > SMAX) ? SMAX[V-1:0] : ((x < SMIN) ? SMIN[V-1:0] : x[V-1:0]);
   endfunction

   logic signed [SW-1:0] ux_e, uy_e, eu_in;
   logic signed [V-1:0]  wr_w, c15_w, m3_w, sq_w, m45_w, feq_w, om_w;
   logic signed [F+2:0]  om_s;

   logic signed [V-1:0] pop_ff [1:6];
   logic                sld_ff [1:6];
   logic signed [V-1:0] eu1_ff, wr1_ff, c15_1_ff;
   logic signed [V-1:0] m3_2_ff, eu2_ff, wr2_ff, c15_2_ff;
   logic signed [V-1:0] t1_3_ff, m45_3_ff, wr3_ff, c15_3_ff;
   logic signed [V-1:0] t4_ff, wr4_ff;
   logic signed [V-1:0] feq5_ff, diff6_ff, res_ff;

   assign ux_e  = SW'(ux);
   assign uy_e  = SW'(uy);
   assign eu_in = ((EX > 0) ? ux_e : ((EX < 0) ? -ux_e : '0)) +
                  ((EY > 0) ? uy_e : ((EY < 0) ? -uy_e : '0));
   assign om_s  = {1'b0, omega};

   d2q9_mulq #(.AW(CW), .BW(V), .V(V), .F(F)) u_wr  (.a(W_C),   .b(rho),     .y(wr_w));
   d2q9_mulq #(.AW(CW), .BW(V), .V(V), .F(F)) u_c15 (.a(C15_C), .b(usq),     .y(c15_w));
   d2q9_mulq #(.AW(CW), .BW(V), .V(V), .F(F)) u_m3  (.a(C3_C),  .b(eu1_ff),  .y(m3_w));
   d2q9_mulq #(.AW(V),  .BW(V), .V(V), .F(F)) u_sq  (.a(eu1_ff), .b(eu1_ff), .y(sq_w));
   d2q9_mulq #(.AW(CW), .BW(V), .V(V), .F(F)) u_m45 (.a(C45_C), .b(eu2_ff),  .y(m45_w));
   d2q9_mulq #(.AW(V),  .BW(V), .V(V), .F(F)) u_feq (.a(wr4_ff), .b(t4_ff),  .y(feq_w));
   d2q9_mulq #(.AW(F+3), .BW(V), .V(V), .F(F)) u_om (.a(om_s),  .b(diff6_ff), .y(om_w));

   always_ff @(posedge clock) begin
      if (en) begin
         pop_ff[1] <= pop;
         sld_ff[1] <= solid;
         for (int k = 2; k <= 6; k++) begin
            pop_ff[k] <= pop_ff[k-1];
            sld_ff[k] <= sld_ff[k-1];
         end
         eu1_ff   <= sat_v(eu_in);
         wr1_ff   <= wr_w;
         c15_1_ff <= c15_w;
         m3_2_ff  <= m3_w;
         eu2_ff   <= sq_w;
         wr2_ff   <= wr1_ff;
         c15_2_ff <= c15_1_ff;
         t1_3_ff  <= sat_v(ONE_S + SW'(m3_2_ff));
         m45_3_ff <= m45_w;
         wr3_ff   <= wr2_ff;
         c15_3_ff <= c15_2_ff;
         t4_ff    <= sat_v(SW'(sat_v(SW'(t1_3_ff) + SW'(m45_3_ff))) - SW'(c15_3_ff));
         wr4_ff   <= wr3_ff;
         feq5_ff  <= feq_w;
         diff6_ff <= sat_v(SW'(pop_ff[5]) - SW'(feq5_ff));
         res_ff   <= sld_ff[6] ? pop_ff[6] : sat_v(SW'(pop_ff[6]) - SW'(om_w));
      end
   end

   assign res = res_ff;

endmodule

// ===== src/d2q9_bgk_cell_collide.sv =====
// Top level of the D2Q9 BGK collide block: moments, velocity divide, lanes, merge.
// Throughput: one cell per cycle while the skid register is empty; the pipeline advances
// as one and the output skid register lets a new request in while one result waits.
// Reset: synchronous, active high; clears the pipeline valids and the output and skid valids
// and sets omega to 1.0.
module d2q9_bgk_cell_collide
   import d2q9_pkg::*;
#(
   parameter int VALUE_WIDTH = 24,
   parameter int FRAC_BITS   = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pop_sw, pop_s, pop_se, pop_w, pop_rest, pop_e, pop_nw, pop_n, pop_ne
   input  logic [((NDIR*VALUE_WIDTH+7)/8)*8-1:0]   req_tdata,
   // solid
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_sw, out_s, out_se, out_w, out_rest, out_e, out_nw, out_n, out_ne,
   // density, vel_x, vel_y
   output logic [((12*VALUE_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [FRAC_BITS+1:0]                   csr_data
);

   localparam int V   = VALUE_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int JW  = V + 3;
   localparam int SW  = ((V > F) ? V : F) + 4;
   localparam int DW  = ((12 * V + 7) / 8) * 8;
   localparam int NST = V + 13;
   localparam logic signed [SW-1:0] SMAX = SW'((longint'(1) << (V - 1)) - 1);
   localparam logic signed [SW-1:0] SMIN = ~SMAX;

   typedef struct packed {
      logic                  solid;
      logic signed [V-1:0]   rho;
      logic [NDIR*V-1:0]     pop;
   } side_type;

   typedef struct packed {
      logic                solid;
      logic signed [V-1:0] rho;
      logic signed [V-1:0] ux;
      logic signed [V-1:0] uy;
   } mrg_type;

   function automatic logic signed [V-1:0] sat_v(input logic signed [SW-1:0] x);
      return (x > SMAX) ? SMAX[V-1:0] : ((x < SMIN) ? SMIN[V-1:0] : x[V-1:0]);
   endfunction

   logic                en;
   logic [NST-1:0]      vld_ff;
   logic [F+1:0]        omega_ff;

   logic [NDIR*V-1:0]   p0_ff;
   logic                solid0_ff;

   logic signed [SW-1:0] rho_in;
   logic signed [JW-1:0] jx_in, jy_in;
   side_type             s1_ff;
   logic signed [JW-1:0] jx1_ff, jy1_ff;

   side_type             dside_ff [V+2];
   logic signed [V-1:0]  qx_w, qy_w;

   logic signed [V-1:0]  sqx_w, sqy_w;
   logic signed [V-1:0]  ux1_ff, uy1_ff, sqx1_ff, sqy1_ff;
   side_type             u1side_ff;
   logic signed [V-1:0]  ux2_ff, uy2_ff, usq2_ff;
   side_type             u2side_ff;

   mrg_type              mrg_ff [7];
   logic signed [V-1:0]  lane_res [NDIR];

   logic [DW-1:0]        out_in, out_data_ff, skid_data_ff;
   logic                 out_v_ff, skid_v_ff, push;

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign push       = en && vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff <= (F + 2)'(longint'(1) << F);
      end else if (csr_valid) begin
         omega_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   always_comb begin
      rho_in = '0;
      jx_in  = '0;
      jy_in  = '0;
      for (int i = 0; i < NDIR; i++) begin
         rho_in = rho_in + SW'($signed(p0_ff[i*V +: V]));
         if (DIR_EX[i] > 0) jx_in = jx_in + JW'($signed(p0_ff[i*V +: V]));
         if (DIR_EX[i] < 0) jx_in = jx_in - JW'($signed(p0_ff[i*V +: V]));
         if (DIR_EY[i] > 0) jy_in = jy_in + JW'($signed(p0_ff[i*V +: V]));
         if (DIR_EY[i] < 0) jy_in = jy_in - JW'($signed(p0_ff[i*V +: V]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff       <= req_tdata[NDIR*V-1:0];
         solid0_ff   <= req_tuser;
         s1_ff.pop   <= p0_ff;
         s1_ff.solid <= solid0_ff;
         s1_ff.rho   <= sat_v(rho_in);
         jx1_ff      <= jx_in;
         jy1_ff      <= jy_in;
         dside_ff[0] <= s1_ff;
         for (int k = 1; k < V + 2; k++) begin
            dside_ff[k] <= dside_ff[k-1];
         end
      end
   end

   d2q9_div #(.V(V), .F(F)) u_div_x (
      .clock(clock), .en(en), .num(jx1_ff), .den(s1_ff.rho), .quo(qx_w)
   );
   d2q9_div #(.V(V), .F(F)) u_div_y (
      .clock(clock), .en(en), .num(jy1_ff), .den(s1_ff.rho), .quo(qy_w)
   );

   d2q9_mulq #(.AW(V), .BW(V), .V(V), .F(F)) u_sqx (.a(qx_w), .b(qx_w), .y(sqx_w));
   d2q9_mulq #(.AW(V), .BW(V), .V(V), .F(F)) u_sqy (.a(qy_w), .b(qy_w), .y(sqy_w));

   always_ff @(posedge clock) begin
      if (en) begin
         ux1_ff    <= qx_w;
         uy1_ff    <= qy_w;
         sqx1_ff   <= sqx_w;
         sqy1_ff   <= sqy_w;
         u1side_ff <= dside_ff[V+1];
         ux2_ff    <= ux1_ff;
         uy2_ff    <= uy1_ff;
         usq2_ff   <= sat_v(SW'(sqx1_ff) + SW'(sqy1_ff));
         u2side_ff <= u1side_ff;
         mrg_ff[0] <= '{solid: u2side_ff.solid, rho: u2side_ff.rho, ux: ux2_ff, uy: uy2_ff};
         for (int k = 1; k < 7; k++) begin
            mrg_ff[k] <= mrg_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < NDIR; i++) begin : g_lane
      d2q9_lane #(.V(V), .F(F), .EX(DIR_EX[i]), .EY(DIR_EY[i])) u_lane (
         .clock (clock),
         .en    (en),
         .ux    (ux2_ff),
         .uy    (uy2_ff),
         .usq   (usq2_ff),
         .rho   (u2side_ff.rho),
         .pop   (u2side_ff.pop[i*V +: V]),
         .solid (u2side_ff.solid),
         .omega (omega_ff),
         .res   (lane_res[i])
      );
   end

   always_comb begin
      out_in = '0;
      for (int i = 0; i < NDIR; i++) begin
         out_in[i*V +: V] = lane_res[i];
      end
      out_in[9*V  +: V] = mrg_ff[6].solid ? '0 : mrg_ff[6].rho;
      out_in[10*V +: V] = mrg_ff[6].solid ? '0 : mrg_ff[6].ux;
      out_in[11*V +: V] = mrg_ff[6].solid ? '0 : mrg_ff[6].uy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_data_ff <= skid_v_ff ? skid_data_ff : out_in;
      end else if (push) begin
         skid_data_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== dv/tb_top.sv =====
// Testbench of the D2Q9 BGK collide block: directed table, random cells, predictor check.
module tb_top;
   import d2q9_pkg::*;

   localparam int VW = 24;
   localparam int FB = 20;
   localparam int DW = NDIR * VW;
   localparam int RW = 12 * VW;
   localparam int LATENCY = VW + 13;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
   localparam longint VMIN = -(64'sd1 <<< (VW - 1));
   localparam longint FX_ONE = 64'sd1 <<< FB;
   localparam longint FX_W0 = ((64'sd4 <<< FB) * 2 + 9) / 18;
   localparam longint FX_W1 = ((64'sd1 <<< FB) * 2 + 9) / 18;
   localparam longint FX_W2 = ((64'sd1 <<< FB) * 2 + 36) / 72;
   localparam longint FX_C3 = 64'sd3 <<< FB;
   localparam longint FX_C45 = (64'sd9 <<< FB) / 2;
   localparam longint FX_C15 = (64'sd3 <<< FB) / 2;
   localparam logic [VW-1:0] PMAX = 24'h7FFFFF;
   localparam logic [VW-1:0] PMIN = 24'h800000;

   typedef struct {
      logic [DW-1:0] pops;
      bit            solid;
      bit            typed;
      logic [RW-1:0] result;
   } cell_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RW-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [FB+1:0] csr_data = '0;

   logic [FB+1:0] omega_q = 22'(FX_ONE);
   logic [RW-1:0] pending_cells [$];
   int n_err = 0;
   int n_sent = 0;
   int n_recv = 0;
   int n_solid = 0;
   int n_omega = 0;
   int cycles = 0;
   bit held_off = 0;
   cell_row_type dir_rows [$];

   string field_names [12] = '{"out_sw", "out_s", "out_se", "out_w", "out_rest", "out_e",
      "out_nw", "out_n", "out_ne", "density", "vel_x", "vel_y"};

   d2q9_bgk_cell_collide #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL d2q9_bgk_cell_collide");
         $finish;
      end
   end

   function automatic longint clamp(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> FB);
   endfunction

   function automatic longint fx_div(longint num, longint den);
      longint q;
      q = (num <<< FB) / den;
      return clamp(q);
   endfunction

   function automatic logic [RW-1:0] collide(logic [DW-1:0] pops, bit solid,
                                             logic [FB+1:0] om);
      logic [RW-1:0] r;
      longint p [NDIR];
      longint rho, jx, jy, ux, uy, usq, w, eu, t, feq, diff;
      int manh;
      r = '0;
      rho = 0; jx = 0; jy = 0; ux = 0; uy = 0;
      for (int i = 0; i < NDIR; i++) p[i] = longint'(signed'(pops[i*VW +: VW]));
      if (solid) begin
         r[DW-1:0] = pops;
         return r;
      end
      for (int i = 0; i < NDIR; i++) begin
         rho += p[i];
         jx += DIR_EX[i] * p[i];
         jy += DIR_EY[i] * p[i];
      end
      rho = clamp(rho);
      if (rho != 0) begin
         ux = fx_div(jx, rho);
         uy = fx_div(jy, rho);
      end
      usq = clamp(fx_mul(ux, ux) + fx_mul(uy, uy));
      for (int i = 0; i < NDIR; i++) begin
         manh = (DIR_EX[i] != 0) + (DIR_EY[i] != 0);
         w = manh == 0 ? FX_W0 : (manh == 1 ? FX_W1 : FX_W2);
         eu = clamp(DIR_EX[i] * ux + DIR_EY[i] * uy);
         t = clamp(FX_ONE + fx_mul(FX_C3, eu));
         t = clamp(t + fx_mul(FX_C45, fx_mul(eu, eu)));
         t = clamp(t - fx_mul(FX_C15, usq));
         feq = fx_mul(fx_mul(w, rho), t);
         diff = clamp(p[i] - feq);
         r[i*VW +: VW] = VW'(clamp(p[i] - fx_mul(longint'(om), diff)));
      end
      r[9*VW +: VW] = VW'(rho);
      r[10*VW +: VW] = VW'(ux);
      r[11*VW +: VW] = VW'(uy);
      return r;
   endfunction

   function automatic logic [DW-1:0] pack9(logic [VW-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8);
      return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
   endfunction

   function automatic logic [DW-1:0] random_cell();
      logic [DW-1:0] d;
      int mode;
      int scale;
      mode = $urandom_range(0, 9);
      scale = $urandom_range(0, 3);
      for (int i = 0; i < NDIR; i++) begin
         if (mode <= 6)
            d[i*VW +: VW] = VW'((((i == 4) ? 466034 : (DIR_EX[i] * DIR_EY[i] != 0 ? 29127
               : 116508)) + $signed($urandom_range(0, 65535)) - 32768) <<< scale);
         else if (mode == 7)
            d[i*VW +: VW] = VW'($urandom);
         else if (mode == 8)
            d[i*VW +: VW] = VW'($signed($urandom_range(0, 511)) - 256);
         else
            d[i*VW +: VW] = ($urandom_range(0, 3) == 0) ? VW'($urandom) : '0;
      end
      return d;
   endfunction

   task automatic send_cell(logic [DW-1:0] pops, bit solid, bit typed, logic [RW-1:0] res);
      int gap;
      req_tvalid <= 1;
      req_tdata <= pops;
      req_tuser <= solid;
      do @(posedge clock); while (!req_tready);
      pending_cells.push_back(typed ? res : collide(pops, solid, omega_q));
      n_sent++;
      if (solid) n_solid++;
      gap = $urandom_range(0, 9);
      gap = gap < 6 ? 0 : (gap < 9 ? $urandom_range(1, 3) : $urandom_range(8, 30));
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_omega(logic [FB+1:0] value);
      wait (pending_cells.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      omega_q = value;
      n_omega++;
      csr_valid <= 0;
   endtask

   // receiver: random stalls plus one long hold-off to back up the pipeline
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_recv++;
            if (pending_cells.size() == 0) begin
               n_err++;
               $error("unexpected result %h", rsp_tdata);
            end else begin
               logic [RW-1:0] want;
               want = pending_cells.pop_front();
               for (int k = 0; k < 12; k++)
                  if (rsp_tdata[k*VW +: VW] !== want[k*VW +: VW]) begin
                     n_err++;
                     $error("%s expected %h actual %h", field_names[k],
                            want[k*VW +: VW], rsp_tdata[k*VW +: VW]);
                  end
            end
         end
         if (!held_off && n_sent >= 700) begin
            held_off = 1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if ($urandom_range(0, 3) == 0)
               stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 40);
         end
      end
   end

   initial begin
      logic [FB+1:0] settings [5];
      cell_row_type row;
      settings = '{22'd0, 22'd2097152, 22'h3FFFFF, 22'd1572864, 22'($urandom)};
      // zero cell: everything zero at omega 1.0
      dir_rows.push_back('{'0, 0, 1, '0});
      dir_rows.push_back('{{NDIR{PMAX}}, 0, 0, '0});
      dir_rows.push_back('{{NDIR{PMIN}}, 0, 0, '0});
      // solid: pass through, zero moments
      dir_rows.push_back('{{NDIR{PMAX}}, 1, 1, {72'd0, {NDIR{PMAX}}}});
      dir_rows.push_back('{{NDIR{PMIN}}, 1, 1, {72'd0, {NDIR{PMIN}}}});
      dir_rows.push_back('{pack9(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX), 1, 1,
         {72'd0, pack9(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX)}});
      dir_rows.push_back('{pack9(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX), 0, 0,
         '0});
      // zero density with momentum, then unit density moving east or north
      dir_rows.push_back('{pack9(0, 0, 0, 24'hF00000, 0, 24'h100000, 0, 0, 0), 0, 0, '0});
      dir_rows.push_back('{pack9(0, 0, 0, 0, 0, 24'h100000, 0, 0, 0), 0, 0, '0});
      dir_rows.push_back('{pack9(0, 0, 0, 0, 0, 0, 0, 24'h100000, 0), 0, 0, '0});
      // negative density
      dir_rows.push_back('{pack9(24'hFF0000, 0, 0, 0, 24'hF00000, 24'h010000, 0, 0, 0), 0, 0,
         '0});
      // large density and large eastward momentum; then symmetric cells with zero velocity
      dir_rows.push_back('{pack9(0, 0, 24'h400000, 24'hC00001, 0, 0, 0, 0, 24'h400000), 0, 0,
         '0});
      dir_rows.push_back('{pack9(24'h01C71C, 24'h01C71C, 24'h01C71C, 24'h01C71C, 24'h071C72,
         24'h01C71C, 24'h01C71C, 24'h01C71C, 24'h01C71C), 0, 0, '0});
      dir_rows.push_back('{{9{24'h0071C7}}, 0, 0, '0});

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_cell(row.pops, row.solid, row.typed, row.result);
      end
      for (int ph = 0; ph <= 5; ph++) begin
         if (ph > 0) begin
            req_tvalid <= 0;
            write_omega(settings[ph-1]);
         end
         repeat (322) send_cell(random_cell(), $urandom_range(0, 9) == 0, 0, '0);
      end
      req_tvalid <= 0;
      wait (pending_cells.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Covered %0d cells (%0d solid), %0d results, %0d omega writes.",
               n_sent, n_solid, n_recv, n_omega);
      if (n_err == 0 && pending_cells.size() == 0)
         $display("PASS d2q9_bgk_cell_collide");
      else
         $display("FAIL d2q9_bgk_cell_collide");
      $finish;
   end

endmodule

// ===== files.f =====
src/d2q9_pkg.sv
src/d2q9_mulq.sv
src/d2q9_div.sv
src/d2q9_lane.sv
src/d2q9_bgk_cell_collide.sv
dv/tb_top.sv
